/* rtl/image_row_column_projection_macros.svh */
// Assertion macros shared by the projection block.
`ifndef IMAGE_ROW_COLUMN_PROJECTION_MACROS_SVH
`define IMAGE_ROW_COLUMN_PROJECTION_MACROS_SVH

// Same-cycle implication.
`define ICP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ICP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/icp_pkg.sv */
package icp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 8;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS = 13;
    localparam int SUM_BITS = 20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [COL_BITS-1:0] index;
        logic [SUM_BITS-1:0] total;
        logic                frame_done;
    } result_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] maxv
    );
        logic [DIM_BITS-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_BITS'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

endpackage

/* rtl/image_row_column_projection.sv */
// Row and column projection of a grayscale frame.
// Pixel channel: pixel_valid / pixel_ready / pixel, raster order, one request
// per cycle, stalls aside. Result channel: result_valid / result_ready with kind,
// index, total and frame_done. Each row ends with a row-sum result; during the
// last row every pixel also yields its column total, ahead of the row result.
// frame_done marks the row result of the last pixel of the frame.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is
// frame_width, 1 is frame_height. Write only while no pixel is in flight; 0
// acts as 1 and values above 4096 act as 4096. cfg_ready is always high.
// Throughput is one pixel per cycle while not stalled, set by the column RAM
// read-modify-write (read at accept, written back as stage one advances,
// same-column hits forwarded). The last pixel of a frame holds the stage
// until both its results are pushed. The column RAM needs no clearing: the
// first row of a frame writes it. Reset: positions and row sum clear, width
// 640, height 480; column RAM keeps its contents. When the receiver stalls,
// results queue in a four-entry buffer; once it fills, pixel_ready drops
// until space frees.
module image_row_column_projection (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [icp_pkg::DIM_BITS-1:0]    cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [icp_pkg::PIXEL_BITS-1:0]  pixel,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            kind,
    output logic [icp_pkg::COL_BITS-1:0]    index,
    output logic [icp_pkg::SUM_BITS-1:0]    total,
    output logic                            frame_done
);
    import icp_pkg::*;

    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic                push_valid;
    logic                push_ready;
    result_t             push_data;
    result_t             result_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = clamp_dim(cfg_data, DIM_BITS'(MAX_WIDTH));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = clamp_dim(cfg_data, DIM_BITS'(MAX_HEIGHT));
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    icp_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    icp_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    assign kind       = result_data.kind;
    assign index      = result_data.index;
    assign total      = result_data.total;
    assign frame_done = result_data.frame_done;

endmodule

/* rtl/icp_accum.sv */
`include "image_row_column_projection_macros.svh"

module icp_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [icp_pkg::PIXEL_BITS-1:0] pixel,
    input  logic [icp_pkg::DIM_BITS-1:0]  frame_width,
    input  logic [icp_pkg::DIM_BITS-1:0]  frame_height,
    output logic                          push_valid,
    input  logic                          push_ready,
    output icp_pkg::result_t              push_data
);
    import icp_pkg::*;

    logic [COL_BITS-1:0] col_pos_reg, col_pos_next;
    logic [ROW_BITS-1:0] row_pos_reg, row_pos_next;
    logic [SUM_BITS-1:0] row_sum_reg, row_sum_next;
    logic [SUM_BITS-1:0] row_total;
    logic                accept;
    logic                last_row;
    logic                end_row;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_phase_reg, s1_phase_next;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic                  s1_first_row_reg;
    logic                  s1_last_row_reg;
    logic                  s1_end_row_reg;
    logic [SUM_BITS-1:0]   s1_row_total_reg;
    logic                  s1_fwd_reg;
    logic [SUM_BITS-1:0]   fwd_data_reg;
    logic                  s1_advance;
    logic                  s1_write;
    logic [SUM_BITS-1:0]   col_base;
    logic [SUM_BITS-1:0]   colsum;

    logic [SUM_BITS-1:0] col_mem [MAX_WIDTH];
    logic [SUM_BITS-1:0] rd_data_reg;

    assign last_row = ({1'b0, row_pos_reg} + DIM_BITS'(1)) >= frame_height;
    assign end_row  = ({1'b0, col_pos_reg} + DIM_BITS'(1)) >= frame_width;
    assign pixel_ready = !s1_valid_reg || s1_advance;
    assign accept = pixel_valid && pixel_ready;
    assign row_total = row_sum_reg + SUM_BITS'(pixel);

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        row_sum_next = row_sum_reg;
        if (accept)
        begin
            if (end_row)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + ROW_BITS'(1);
                row_sum_next = '0;
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_BITS'(1);
                row_sum_next = row_total;
            end
        end
    end

    assign col_base = s1_fwd_reg ? fwd_data_reg : rd_data_reg;
    assign colsum   = s1_first_row_reg ? SUM_BITS'(s1_pixel_reg)
                                       : col_base + SUM_BITS'(s1_pixel_reg);

    always_comb
    begin
        push_valid    = 1'b0;
        push_data     = '{KIND_COL, s1_col_reg, colsum, 1'b0};
        s1_advance    = 1'b1;
        s1_phase_next = s1_phase_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_row_reg && !s1_phase_reg)
            begin
                push_valid = 1'b1;
                if (s1_end_row_reg)
                begin
                    s1_advance = 1'b0;
                    if (push_ready)
                    begin
                        s1_phase_next = 1'b1;
                    end
                end
                else
                begin
                    s1_advance = push_ready;
                end
            end
            else if (s1_end_row_reg)
            begin
                push_valid = 1'b1;
                push_data  = '{KIND_ROW, s1_row_reg, s1_row_total_reg, s1_last_row_reg};
                s1_advance = push_ready;
            end
        end
        if (s1_advance)
        begin
            s1_phase_next = 1'b0;
        end
    end

    assign s1_write = s1_valid_reg && s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            row_sum_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            row_sum_reg  <= row_sum_next;
            s1_valid_reg <= s1_valid_next;
            s1_phase_reg <= s1_phase_next;
        end
    end

    // hold stage payload until the next request enters
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= pixel;
            s1_col_reg       <= col_pos_reg;
            s1_row_reg       <= row_pos_reg;
            s1_first_row_reg <= (row_pos_reg == '0);
            s1_last_row_reg  <= last_row;
            s1_end_row_reg   <= end_row;
            s1_row_total_reg <= row_total;
            s1_fwd_reg       <= s1_write && (s1_col_reg == col_pos_reg);
            fwd_data_reg     <= colsum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= col_mem[col_pos_reg];
        end
        if (s1_write)
        begin
            col_mem[s1_col_reg] <= colsum;
        end
    end

    `ICP_ASSERT_IMPL(a_push_from_stage, clk, rst_n, push_valid, s1_valid_reg,
        "push without a stage-one request")
    `ICP_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept, s1_valid_reg,
        "accepted request missing from stage one")
    `ICP_ASSERT_IMPL(a_phase_only_frame_end, clk, rst_n, s1_phase_reg,
        s1_valid_reg && s1_last_row_reg && s1_end_row_reg,
        "split push outside the last pixel of a frame")
    `ICP_ASSERT_IMPL(a_no_write_on_stall, clk, rst_n, s1_valid_reg && !s1_advance,
        !accept, "request accepted while stage one stalls")

endmodule

/* rtl/icp_out_fifo.sv */
`include "image_row_column_projection_macros.svh"

module icp_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push_valid,
    output logic                                push_ready,
    input  icp_pkg::result_t                    push_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output icp_pkg::result_t                    result_data
);
    import icp_pkg::*;

    result_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic                     push;
    logic                     pop;

    assign push_ready   = count_reg != FIFO_CNT_BITS'(FIFO_DEPTH);
    assign result_valid = count_reg != '0;
    assign result_data  = entry_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = result_valid && result_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ICP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue count above depth")
    `ICP_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + FIFO_CNT_BITS'(1), "queue count did not rise")
    `ICP_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push,
        count_reg == $past(count_reg) - FIFO_CNT_BITS'(1), "queue count did not fall")

endmodule

/* dv/tb_image_row_column_projection.sv */
module tb_image_row_column_projection;
    timeunit 1ns;
    timeprecision 1ps;

    import icp_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 400;
    localparam int PRINT_CAP      = 50;
    localparam int SUM_CEIL       = (1 << SUM_BITS) - 1;

    typedef struct {
        logic                idx;
        logic [DIM_BITS-1:0] data;
    } reg_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = REG_FRAME_WIDTH;
    logic [DIM_BITS-1:0]   cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    logic [PIXEL_BITS-1:0] pixel = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  kind;
    logic [COL_BITS-1:0]   index;
    logic [SUM_BITS-1:0]   total;
    logic                  frame_done;

    // predictor state
    logic [SUM_BITS-1:0]   column_totals [MAX_WIDTH];
    int                    row_acc = 0;
    logic [COL_BITS-1:0]   col_pos = '0;
    logic [ROW_BITS-1:0]   row_pos = '0;
    logic [DIM_BITS-1:0]   width_setting = WIDTH_RESET;
    logic [DIM_BITS-1:0]   height_setting = HEIGHT_RESET;

    result_t               projections_due [$];
    logic [PIXEL_BITS-1:0] pixel_queue [$];
    reg_write_t            reg_queue [$];

    int  pixels_pushed = 0;
    int  pixels_accepted = 0;
    int  writes_pushed = 0;
    int  writes_done = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int  hold_left = 0;

    image_row_column_projection uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .index        (index),
        .total        (total),
        .frame_done   (frame_done)
    );

    always #5 clk = ~clk;

    function automatic int effective_dim(input logic [DIM_BITS-1:0] v, input int cap);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > cap)
        begin
            return cap;
        end
        return int'(v);
    endfunction

    function automatic int saturate(input int v);
        return (v > SUM_CEIL) ? SUM_CEIL : v;
    endfunction

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pixel_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return '1;
        end
        return PIXEL_BITS'($urandom_range(0, 255));
    endfunction

    // pixels needed to reach the end of the current frame
    function automatic int frame_remainder();
        int w;
        int h;
        int in_row;
        int rows_after;
        w = effective_dim(width_setting, MAX_WIDTH);
        h = effective_dim(height_setting, MAX_HEIGHT);
        in_row = (int'(col_pos) + 1 >= w) ? 1 : w - int'(col_pos);
        rows_after = (int'(row_pos) + 1 >= h) ? 0 : h - int'(row_pos) - 1;
        return in_row + rows_after * w;
    endfunction

    task automatic project_pixel(input logic [PIXEL_BITS-1:0] p);
        int      w;
        int      h;
        int      colv;
        bit      last_row;
        bit      end_row;
        result_t r;
        w = effective_dim(width_setting, MAX_WIDTH);
        h = effective_dim(height_setting, MAX_HEIGHT);
        last_row = (int'(row_pos) + 1 >= h);
        end_row = (int'(col_pos) + 1 >= w);
        row_acc = saturate(row_acc + int'(p));
        colv = (row_pos == '0) ? int'(p) : saturate(int'(column_totals[col_pos]) + int'(p));
        column_totals[col_pos] = SUM_BITS'(colv);
        if (last_row)
        begin
            r.kind = KIND_COL;
            r.index = col_pos;
            r.total = SUM_BITS'(colv);
            r.frame_done = 1'b0;
            projections_due.push_back(r);
        end
        if (end_row)
        begin
            r.kind = KIND_ROW;
            r.index = row_pos;
            r.total = SUM_BITS'(row_acc);
            r.frame_done = last_row;
            projections_due.push_back(r);
            row_acc = 0;
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + ROW_BITS'(1);
        end
        else
        begin
            col_pos = col_pos + COL_BITS'(1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // pixel driver; the prediction runs on every accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel <= '0;
            send_gap = 0;
            row_acc = 0;
            col_pos = '0;
            row_pos = '0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                project_pixel(pixel);
                pixels_accepted++;
            end
            if (!pixel_valid || pixel_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pixel_valid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    pixel <= pixel_queue.pop_front();
                    pixel_valid <= 1'b1;
                    send_gap = calm ? 0 : idle_length();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t wr;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data <= '0;
            width_setting = WIDTH_RESET;
            height_setting = HEIGHT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    width_setting = cfg_data;
                end
                else
                begin
                    height_setting = cfg_data;
                end
                writes_done++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_queue.size() != 0)
                begin
                    wr = reg_queue.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= wr.idx;
                    cfg_data <= wr.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (projections_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result kind %0d index %0d total %0d",
                        kind, index, total));
                end
                else
                begin
                    due = projections_due.pop_front();
                    if (kind !== due.kind)
                    begin
                        report_mismatch($sformatf("kind: expected %0d, got %0d",
                            due.kind, kind));
                    end
                    if (index !== due.index)
                    begin
                        report_mismatch($sformatf("index: expected %0d, got %0d",
                            due.index, index));
                    end
                    if (total !== due.total)
                    begin
                        report_mismatch($sformatf("total at index %0d: expected %0d, got %0d",
                            due.index, due.total, total));
                    end
                    if (frame_done !== due.frame_done)
                    begin
                        report_mismatch($sformatf("frame_done at index %0d: expected %0d, got %0d",
                            due.index, due.frame_done, frame_done));
                    end
                end
            end
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                recv_gap = (calm || $urandom_range(0, 3) != 0) ? 0 : idle_length();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
                 || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("image_row_column_projection regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pixel(input logic [PIXEL_BITS-1:0] p);
        pixel_queue.push_back(p);
        pixels_pushed++;
    endtask

    task automatic push_frame_rest();
        repeat (frame_remainder()) push_pixel(pixel_value());
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_BITS-1:0] data);
        reg_write_t wr;
        wr.idx = idx;
        wr.data = data;
        reg_queue.push_back(wr);
        writes_pushed++;
        do @(posedge clk); while (writes_done != writes_pushed);
    endtask

    // hold until every request is taken and every result is back
    task automatic settle();
        do @(posedge clk);
        while (pixels_accepted != pixels_pushed || projections_due.size() != 0
               || writes_done != writes_pushed);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mid-frame width changes only shrink once the first row is complete
    task automatic retune();
        int wval;
        if ($urandom_range(0, 1) == 0)
        begin
            if (row_pos == '0)
            begin
                wval = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 48);
            end
            else
            begin
                wval = $urandom_range(0, effective_dim(width_setting, MAX_WIDTH));
            end
            write_reg(REG_FRAME_WIDTH, DIM_BITS'(wval));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_FRAME_HEIGHT, DIM_BITS'(($urandom_range(0, 9) != 0)
                ? $urandom_range(0, 6) : $urandom_range(7, 20)));
        end
    endtask

    initial
    begin
        int random_sent;
        int burst;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes, then shrink the row under a pixel already past its end
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd128);
        settle();
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(2));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(2));
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd255);
        settle();

        // zero sizes act as one
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        push_pixel(8'd255);
        push_pixel(8'd0);
        settle();

        // height dropped under the current row ends the frame at row end
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(3));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(3));
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        settle();
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(1));
        push_pixel(8'd255);
        push_pixel(8'd1);
        settle();

        // oversized settings act as the maximum
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(MAX_HEIGHT + 1));
        repeat (20) push_pixel(pixel_value());
        settle();
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(4));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(3));
        push_frame_rest();
        settle();

        // stall the receiver while the sender keeps going
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(40));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(1));
        calm = 1'b1;
        @(posedge clk);
        hold_req <= ~hold_req;
        push_frame_rest();
        settle();
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(MAX_WIDTH));
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(MAX_HEIGHT));
        push_pixel(pixel_value());
        settle();
        write_reg(REG_FRAME_HEIGHT, DIM_BITS'(1));
        write_reg(REG_FRAME_WIDTH, DIM_BITS'(24));
        push_frame_rest();

        while (random_sent < RANDOM_PIXELS)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
            begin
                retune();
            end
            if ($urandom_range(0, 3) != 0)
            begin
                burst = frame_remainder();
            end
            else
            begin
                burst = $urandom_range(1, 20);
            end
            repeat (burst) push_pixel(pixel_value());
            random_sent += burst;
        end

        settle();
        if (error_count == 0)
        begin
            $display("image_row_column_projection regression: pass");
        end
        else
        begin
            $display("image_row_column_projection regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/icp_pkg.sv
rtl/icp_accum.sv
rtl/icp_out_fifo.sv
rtl/image_row_column_projection.sv
dv/tb_image_row_column_projection.sv
